@@ src/ist_pkg.sv @@
`default_nettype none
package ist_pkg;

  // default number of cells in the store
  localparam int unsigned CapacityDef = 16;

  localparam int unsigned ValueW = 32;
  localparam int unsigned FuncW  = 2;
  localparam int unsigned StatW  = 2;
  localparam int unsigned MembW  = 5;

  // operation codes carried on func_i
  localparam logic [FuncW-1:0] FuncTest   = 2'd0;
  localparam logic [FuncW-1:0] FuncInsert = 2'd1;
  localparam logic [FuncW-1:0] FuncRemove = 2'd2;

  // result status codes
  localparam logic [StatW-1:0] StatDone    = 2'd0;
  localparam logic [StatW-1:0] StatPresent = 2'd1;
  localparam logic [StatW-1:0] StatAbsent  = 2'd2;
  localparam logic [StatW-1:0] StatFull    = 2'd3;

  // request broadcast from the control to every cell
  typedef struct packed {
    logic              insert;
    logic              remove;
    logic [ValueW-1:0] value;
  } ist_req_t;

endpackage
`default_nettype wire

@@ src/integer_set_table.sv @@
// done_o strobes once the token has passed launch_q, every cell register of the chain and done_q
// one transaction at a time: a new one is taken only after the token has left the top cell of the chain
// busy is high from the accept until the cycle in which done_o strobes
// reset (async, active low) empties the set; cell contents are left unset
// the receiver cannot stall: each result is shown on done_o for exactly one cycle
`default_nettype none
module integer_set_table #(
  parameter int unsigned CAPACITY = ist_pkg::CapacityDef
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [ist_pkg::FuncW-1:0]          func_i,
  input  wire logic signed [ist_pkg::ValueW-1:0]  value_i,
  output logic                                    done_o,
  output logic                                    was_present_o,
  output logic [ist_pkg::StatW-1:0]               status_o,
  output logic [ist_pkg::MembW-1:0]               member_count_o
);
  import ist_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(CAPACITY);

  // control state
  logic            active_q, launch_q, done_q;
  logic [CntW-1:0] count_q, count_d;
  ist_req_t        req_q;

  // result registers
  logic             was_present_q;
  logic [StatW-1:0] status_q, status_d;
  logic [MembW-1:0] member_count_q;

  // cell chain wiring
  logic [ValueW-1:0]  entry_w [CAPACITY];
  logic [CAPACITY:0]  tok_w;
  logic [CAPACITY:0]  found_w;

  logic accept, fin, present, full;

  assign accept = start && !active_q;
  assign busy   = active_q;

  // token enters cell 0 the cycle after the transaction is taken
  assign tok_w[0]   = launch_q;
  assign found_w[0] = 1'b0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [ValueW-1:0] next_entry;
    if (g == CAPACITY - 1) begin : g_last
      // top cell has no upper neighbor; on compaction it keeps its own value
      assign next_entry = entry_w[g];
    end else begin : g_mid
      assign next_entry = entry_w[g+1];
    end

    ist_cell #(
      .CAPACITY (CAPACITY),
      .INDEX    (g)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .req_i        (req_q),
      .count_i      (count_q),
      .tok_i        (tok_w[g]),
      .found_i      (found_w[g]),
      .next_entry_i (next_entry),
      .tok_o        (tok_w[g+1]),
      .found_o      (found_w[g+1]),
      .entry_o      (entry_w[g])
    );
  end

  // token leaving the top cell closes the transaction
  assign fin     = tok_w[CAPACITY];
  assign present = found_w[CAPACITY];
  assign full    = (count_q == CntMax);

  always_comb begin
    status_d = StatDone;
    count_d  = count_q;
    if (req_q.insert) begin
      if (present) begin
        status_d = StatPresent;
      end else if (full) begin
        status_d = StatFull;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end else if (req_q.remove) begin
      if (!present) begin
        status_d = StatAbsent;
      end else begin
        count_d = count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      launch_q <= 1'b0;
      done_q   <= 1'b0;
      count_q  <= '0;
    end else begin
      launch_q <= accept;
      done_q   <= fin;
      if (accept) begin
        active_q <= 1'b1;
      end else if (fin) begin
        active_q <= 1'b0;
      end
      if (fin) begin
        count_q <= count_d;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.insert <= (func_i == FuncInsert);
      req_q.remove <= (func_i == FuncRemove);
      req_q.value  <= value_i;
    end
    if (fin) begin
      was_present_q  <= present;
      status_q       <= status_d;
      member_count_q <= MembW'(count_d);
    end
  end

  assign done_o         = done_q;
  assign was_present_o  = was_present_q;
  assign status_o       = status_q;
  assign member_count_o = member_count_q;

  // only one transaction walks the chain at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(tok_w))
    else $error("more than one token in the cell chain");

  // fill count never passes the number of cells
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntMax)
    else $error("fill count above capacity");

  // the result strobe lands as the block frees up
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("result shown while still busy");

  // a taken transaction starts the walk on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> (busy && launch_q))
    else $error("accepted transaction did not launch");

  // a refused insert reports a full store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (done_o && (status_o == StatFull)) |-> (member_count_o == MembW'(CAPACITY)))
    else $error("full status with store not full");

endmodule
`default_nettype wire

@@ src/ist_cell.sv @@
`default_nettype none
module ist_cell #(
  parameter int unsigned CAPACITY = ist_pkg::CapacityDef,
  parameter int unsigned INDEX    = 0
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire ist_pkg::ist_req_t                     req_i,
  input  wire logic [$clog2(CAPACITY+1)-1:0]         count_i,
  input  wire logic                                  tok_i,
  input  wire logic                                  found_i,
  input  wire logic [ist_pkg::ValueW-1:0]            next_entry_i,
  output logic                                       tok_o,
  output logic                                       found_o,
  output logic [ist_pkg::ValueW-1:0]                 entry_o
);
  import ist_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0] Idx = CntW'(INDEX);

  logic [ValueW-1:0] entry_q, entry_d;
  logic              tok_q, found_q;
  logic              held, hit, found_here;

  // cell holds a value while its index is below the fill count
  assign held       = count_i > Idx;
  assign hit        = held && (entry_q == req_i.value);
  assign found_here = found_i | hit;

  always_comb begin
    entry_d = entry_q;
    if (tok_i && req_i.remove && found_here && held) begin
      // compaction: take the upper neighbor's value
      entry_d = next_entry_i;
    end else if (tok_i && req_i.insert && !found_i && (count_i == Idx)) begin
      // first free cell, no match below it
      entry_d = req_i.value;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q   <= 1'b0;
      found_q <= 1'b0;
    end else begin
      tok_q   <= tok_i;
      found_q <= tok_i & found_here;
    end
  end

  assign tok_o   = tok_q;
  assign found_o = found_q;
  assign entry_o = entry_q;

endmodule
`default_nettype wire

@@ bench/ist_checker.sv @@
module ist_checker #(
  parameter int unsigned CAPACITY = ist_pkg::CapacityDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       busy_i,
  input  logic [ist_pkg::FuncW-1:0]  func_i,
  input  logic [ist_pkg::ValueW-1:0] value_i,
  input  logic                       done_i,
  input  logic                       was_present_i,
  input  logic [ist_pkg::StatW-1:0]  status_i,
  input  logic [ist_pkg::MembW-1:0]  member_count_i,
  output int                         fail_count_o,
  output int                         pending_o,
  output int                         checked_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ist_pkg::*;

  typedef struct packed {
    logic             was_present;
    logic [StatW-1:0] status;
    logic [MembW-1:0] member_count;
  } set_result_t;

  // shadow copy of the set, in insertion order
  logic [ValueW-1:0] cells [CAPACITY];
  int unsigned       held;
  set_result_t       expected_q [$];

  // applies one transaction to the shadow set and returns its result
  function automatic set_result_t apply_request(logic [FuncW-1:0] f, logic [ValueW-1:0] v);
    set_result_t r;
    int          hit;
    hit = -1;
    for (int i = 0; i < held; i++) begin
      if (hit < 0 && cells[i] == v) hit = i;
    end
    r.status = StatDone;
    case (f)
      FuncInsert: begin
        if (hit >= 0) r.status = StatPresent;
        else if (held >= CAPACITY) r.status = StatFull;
        else begin
          cells[held] = v;
          held++;
        end
      end
      FuncRemove: begin
        if (hit < 0) r.status = StatAbsent;
        else begin
          // close the gap, keeping order
          for (int i = hit; i + 1 < held; i++) cells[i] = cells[i+1];
          held--;
        end
      end
      default: ;  // lookup, spare code included
    endcase
    r.was_present  = (hit >= 0);
    r.member_count = MembW'(held);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    set_result_t want;
    if (!rst_ni) begin
      held = 0;
      expected_q.delete();
      pending_o = 0;
    end else begin
      // retire first, so a result and a new transaction on one edge stay in order
      if (done_i) begin
        if (expected_q.size() == 0) begin
          $error("result strobe with no transaction outstanding");
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          checked_o++;
          if (was_present_i !== want.was_present) begin
            $error("was_present: expected %0d, got %0d", want.was_present, was_present_i);
            fail_count_o++;
          end
          if (status_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_i);
            fail_count_o++;
          end
          if (member_count_i !== want.member_count) begin
            $error("member_count: expected %0d, got %0d", want.member_count, member_count_i);
            fail_count_o++;
          end
        end
      end
      if (start_i && !busy_i) expected_q.push_back(apply_request(func_i, value_i));
      pending_o = expected_q.size();
    end
  end

endmodule

@@ bench/integer_set_table_tb.sv @@
module integer_set_table_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ist_pkg::*;

  // func code 3 has no operation of its own; the block treats it as a lookup
  localparam logic [FuncW-1:0] FuncSpare = 2'd3;

  localparam int unsigned NumRandom = 1024;
  localparam int unsigned PoolSize  = 24;   // more than the capacity so fills hit the limit
  localparam int unsigned Latency   = CapacityDef + 2;

  logic                     clk   = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic [FuncW-1:0]         func  = FuncTest;
  logic signed [ValueW-1:0] value = '0;

  logic             busy;
  logic             done;
  logic             was_present;
  logic [StatW-1:0] status;
  logic [MembW-1:0] member_count;

  int fail_count;
  int pending;
  int checked;

  int unsigned       sent [4];     // transactions per func code
  int unsigned       idle_mode;    // 0 back to back, 1 long random gaps, 2 short gaps
  logic [ValueW-1:0] pool [PoolSize];
  logic [ValueW-1:0] strays [$];   // random values that were offered for insertion

  always #5 clk = ~clk;

  integer_set_table #(
    .CAPACITY      (CapacityDef)
  ) u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .start         (start),
    .busy          (busy),
    .func_i        (func),
    .value_i       (value),
    .done_o        (done),
    .was_present_o (was_present),
    .status_o      (status),
    .member_count_o(member_count)
  );

  // watches both sides, keeps the shadow set and compares every result
  ist_checker #(
    .CAPACITY      (CapacityDef)
  ) u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .start_i       (start),
    .busy_i        (busy),
    .func_i        (func),
    .value_i       (value),
    .done_i        (done),
    .was_present_i (was_present),
    .status_i      (status),
    .member_count_i(member_count),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  // one transaction: optional idle gap, then hold start until the block takes it
  // called and returns on a rising edge; start stays high when the next gap is zero
  task automatic issue(input logic [FuncW-1:0] f, input logic [ValueW-1:0] v);
    int unsigned gap;
    case (idle_mode)
      0:       gap = 0;
      1:       gap = $urandom_range(0, 18);
      default: gap = $urandom_range(0, 3);
    endcase
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    func  <= f;
    value <= v;
    // busy is read before the edge updates it, so this edge is the accept
    do @(posedge clk); while (busy);
    sent[f]++;
  endtask

  // sender holds off until every outstanding transaction has returned
  task automatic settle();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  function automatic logic [ValueW-1:0] from_pool();
    return pool[$urandom_range(0, PoolSize - 1)];
  endfunction

  initial begin
    logic [FuncW-1:0]  f;
    logic [ValueW-1:0] v;
    int unsigned       roll;
    bit                filling;

    foreach (pool[i]) pool[i] = $urandom();
    // keep the extremes of the value range in play
    pool[0] = 32'h8000_0000;
    pool[1] = 32'h7FFF_FFFF;
    pool[2] = '0;
    pool[3] = '1;
    filling = 1'b0;
    idle_mode = 1;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty set, extremes, duplicates, compaction, full store
    issue(FuncTest,   '0);               // lookup on empty set
    issue(FuncRemove, '0);               // removal of an absent value
    issue(FuncInsert, 32'h8000_0000);
    issue(FuncInsert, 32'h7FFF_FFFF);
    issue(FuncInsert, '1);
    issue(FuncInsert, '0);
    issue(FuncInsert, 32'h7FFF_FFFF);    // duplicate insert
    issue(FuncTest,   32'h8000_0000);    // lookup hit
    issue(FuncSpare,  '1);               // spare code acts as lookup
    issue(FuncRemove, 32'h7FFF_FFFF);    // remove from the middle, cells above shift down
    for (int i = 1; i <= 13; i++) issue(FuncInsert, 32'h1000_0001 * i);
    issue(FuncInsert, 32'h0BAD_F00D);    // refused, store full
    issue(FuncInsert, '1);               // duplicate while full
    issue(FuncRemove, 32'h8000_0000);    // remove the first cell
    issue(FuncSpare,  32'h8000_0000);    // spare-code miss
    issue(FuncRemove, 32'h1000_0001 * 13); // remove the last cell
    settle();

    // random: alternate fill and drain phases over a small value pool so the
    // set swings between empty and full; a few values come from outside it
    for (int n = 0; n < NumRandom; n++) begin
      if (n % 40 == 0) idle_mode = $urandom_range(0, 2);
      if (n % 64 == 0) filling = !filling;
      if (n == NumRandom / 2) settle();
      roll = $urandom_range(0, 99);
      if (roll < 5) f = FuncSpare;
      else if (roll < 25) f = FuncTest;
      else if (roll < (filling ? 80 : 45)) f = FuncInsert;
      else f = FuncRemove;
      roll = $urandom_range(0, 39);
      case (f)
        FuncInsert: begin
          if (roll == 0) begin
            v = $urandom();
            strays.push_back(v);
          end else v = from_pool();
        end
        FuncRemove: begin
          if (roll < 4 && strays.size() > 0) v = strays.pop_front();
          else if (roll < 8) v = $urandom();
          else v = from_pool();
        end
        default: begin
          if (roll < 4) v = $urandom();
          else if (roll < 6 && strays.size() > 0) v = strays[0];
          else v = from_pool();
        end
      endcase
      issue(f, v);
    end

    // drain, then give the block time to show any stray strobe
    settle();
    repeat (Latency) @(posedge clk);

    $display("sent %0d transactions: %0d lookups, %0d inserts, %0d removes, %0d on code 3",
             sent[FuncTest] + sent[FuncInsert] + sent[FuncRemove] + sent[FuncSpare],
             sent[FuncTest], sent[FuncInsert], sent[FuncRemove], sent[FuncSpare]);
    $display("compared %0d results against the shadow set", checked);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #(3_000_000);
    $display("timeout with %0d transactions outstanding", pending);
    $display("== FAIL ==");
    $finish;
  end

endmodule
